>>> design/voice_waveform_oscillator_defines.svh
// ----------------------------------------------------------------------------
// voice waveform oscillator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef VOICE_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define VOICE_WAVEFORM_OSCILLATOR_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define VWO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define VWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vwo_pkg.sv
// ----------------------------------------------------------------------------
// vwo_pkg
// codes, item type and helpers shared by the voice oscillator modules
// ----------------------------------------------------------------------------
package vwo_pkg;

  // item operation codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  // register addresses
  localparam logic [2:0] ADDR_FREQ_LO = 3'd0;
  localparam logic [2:0] ADDR_FREQ_HI = 3'd1;
  localparam logic [2:0] ADDR_PW_LO   = 3'd2;
  localparam logic [2:0] ADDR_PW_HI   = 3'd3;
  localparam logic [2:0] ADDR_CTRL    = 3'd4;

  // waveform modes
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_TRI   = 3'd1;
  localparam logic [2:0] MODE_SAW   = 3'd2;
  localparam logic [2:0] MODE_PULSE = 3'd3;
  localparam logic [2:0] MODE_NOISE = 3'd4;
  localparam logic [2:0] MODE_TEST  = 3'd5;

  // control register bit positions
  localparam int CTRL_TEST_BIT  = 3;
  localparam int CTRL_TRI_BIT   = 4;
  localparam int CTRL_SAW_BIT   = 5;
  localparam int CTRL_PULSE_BIT = 6;
  localparam int CTRL_NOISE_BIT = 7;

  localparam logic [22:0] LFSR_RESET = 23'h7FFFF8;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
  } item_t;

  // latest set bit in tri, saw, pulse, noise, test order wins
  function automatic logic [2:0] ctrl_decode(input logic [7:0] v, input logic [2:0] mode);
    logic [2:0] m;
    m = mode;
    priority if (v[CTRL_TEST_BIT])  m = MODE_TEST;
    else if (v[CTRL_NOISE_BIT])     m = MODE_NOISE;
    else if (v[CTRL_PULSE_BIT])     m = MODE_PULSE;
    else if (v[CTRL_SAW_BIT])       m = MODE_SAW;
    else if (v[CTRL_TRI_BIT])       m = MODE_TRI;
    else                            m = mode;
    return m;
  endfunction

  function automatic logic [7:0] ctrl_encode(input logic [2:0] mode);
    logic [7:0] v;
    v = '0;
    unique case (mode)
      MODE_TRI:   v[CTRL_TRI_BIT]   = 1'b1;
      MODE_SAW:   v[CTRL_SAW_BIT]   = 1'b1;
      MODE_PULSE: v[CTRL_PULSE_BIT] = 1'b1;
      MODE_NOISE: v[CTRL_NOISE_BIT] = 1'b1;
      MODE_TEST:  v[CTRL_TEST_BIT]  = 1'b1;
      default:    v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [22:0] lfsr_advance(input logic [22:0] r);
    return {r[21:0], r[22] ^ r[17]};
  endfunction

  function automatic logic [7:0] noise_pick(input logic [22:0] r);
    return {r[20], r[18], r[14], r[11], r[9], r[5], r[2], r[0]};
  endfunction

endpackage

>>> design/vwo_if.sv
// ----------------------------------------------------------------------------
// vwo channel interfaces
// valid/ready command and result channels of the voice oscillator
// ----------------------------------------------------------------------------
interface vwo_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] reg_addr;
  logic [7:0] write_data;

  modport source (output valid, output func, output reg_addr, output write_data,
                  input ready);
  modport sink (input valid, input func, input reg_addr, input write_data,
                output ready);
endinterface

interface vwo_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

>>> design/voice_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// voice_waveform_oscillator
// one sound-chip voice: phase accumulator waveform generator with registers
// ----------------------------------------------------------------------------
// Takes one command beat per cycle (tick, register write, register read or
// restart) while no stalled result holds it back, and returns exactly one
// result beat for each, in order. A command sits in an input register while
// the 25-bit phase add, the noise lfsr step and the waveform or read-back
// select run; the byte then lands in the result register, from which the
// result beat is offered until it is taken. The input register empties as
// soon as its byte moves on, so one more command is still taken while a
// result waits; a further command waits for that result beat.
`include "voice_waveform_oscillator_defines.svh"

module voice_waveform_oscillator import vwo_pkg::*; #(
  parameter int FREQ_SHIFT = 3
) (
  input logic       clk,
  input logic       rst,
  vwo_cmd_if.sink   cmd,
  vwo_res_if.source res
);

  logic       s1_valid;
  item_t      s1_item;
  logic       s1_go;
  logic       out_valid;
  logic [7:0] out_byte;

  logic [15:0] freq_word;
  logic [11:0] pulse_width;
  logic [2:0]  wave_mode;
  logic [7:0]  read_data;
  logic [7:0]  wave;
  logic [7:0]  res_byte;

  assign s1_go     = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item <= '{func: cmd.func, reg_addr: cmd.reg_addr, write_data: cmd.write_data};
    end
  end

  vwo_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .item        (s1_item),
    .freq_word   (freq_word),
    .pulse_width (pulse_width),
    .wave_mode   (wave_mode),
    .read_data   (read_data)
  );

  vwo_osc #(
    .FREQ_SHIFT (FREQ_SHIFT)
  ) u_osc (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .item        (s1_item),
    .freq_word   (freq_word),
    .pulse_width (pulse_width),
    .wave_mode   (wave_mode),
    .wave        (wave)
  );

  always_comb begin
    unique case (s1_item.func)
      FUNC_TICK: res_byte = wave;
      FUNC_READ: res_byte = read_data;
      default:   res_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte <= res_byte;
    end
  end

  assign res.valid    = out_valid;
  assign res.out_byte = out_byte;

  // a held command must survive a stalled result beat
  `VWO_ASSERT_NEXT(a_s1_holds, s1_valid && out_valid && !res.ready, s1_valid,
                   "pending command lost while result stalled")
  `VWO_ASSERT_NEXT(a_go_fills_out, s1_go, out_valid, "processed command gave no result")

endmodule

>>> design/vwo_regs.sv
// ----------------------------------------------------------------------------
// vwo_regs
// frequency, pulse width and control registers with their read-back path
// ----------------------------------------------------------------------------
module vwo_regs import vwo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  item_t       item,
  output logic [15:0] freq_word,
  output logic [11:0] pulse_width,
  output logic [2:0]  wave_mode,
  output logic [7:0]  read_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_word   <= '0;
      pulse_width <= '0;
      wave_mode   <= MODE_NONE;
    end else if (go && item.func == FUNC_WRITE) begin
      unique case (item.reg_addr)
        ADDR_FREQ_LO: freq_word[7:0]    <= item.write_data;
        ADDR_FREQ_HI: freq_word[15:8]   <= item.write_data;
        ADDR_PW_LO:   pulse_width[7:0]  <= item.write_data;
        ADDR_PW_HI:   pulse_width[11:8] <= item.write_data[3:0];
        ADDR_CTRL:    wave_mode <= ctrl_decode(item.write_data, wave_mode);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (item.reg_addr)
      ADDR_FREQ_LO: read_data = freq_word[7:0];
      ADDR_FREQ_HI: read_data = freq_word[15:8];
      ADDR_PW_LO:   read_data = pulse_width[7:0];
      ADDR_PW_HI:   read_data = {4'b0, pulse_width[11:8]};
      ADDR_CTRL:    read_data = ctrl_encode(wave_mode);
      default:      read_data = '0;
    endcase
  end

endmodule

>>> design/vwo_osc.sv
// ----------------------------------------------------------------------------
// vwo_osc
// phase accumulator, noise source and waveform shaping for one tick
// ----------------------------------------------------------------------------
`include "voice_waveform_oscillator_defines.svh"

module vwo_osc import vwo_pkg::*; #(
  parameter int FREQ_SHIFT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  item_t       item,
  input  logic [15:0] freq_word,
  input  logic [11:0] pulse_width,
  input  logic [2:0]  wave_mode,
  output logic [7:0]  wave
);

  logic [24:0] phase, phase_next;
  logic        last_noise_bit, last_noise_bit_next;
  logic [7:0]  noise_byte, noise_byte_next;
  logic [22:0] noise_lfsr, noise_lfsr_next;

  logic [24:0] inc, step, phase_sum;
  logic [22:0] lfsr_step;
  logic        noise_flip;

  assign inc        = 25'(freq_word) << FREQ_SHIFT;
  assign step       = (wave_mode == MODE_TRI) ? {inc[23:0], 1'b0} : inc;
  assign phase_sum  = phase + step;
  assign lfsr_step  = lfsr_advance(noise_lfsr);
  assign noise_flip = phase_sum[21] != last_noise_bit;

  always_comb begin
    unique case (wave_mode)
      MODE_TRI:   wave = phase_sum[24] ? ~phase_sum[23:16] : phase_sum[23:16];
      MODE_SAW:   wave = phase_sum[23:16];
      MODE_PULSE: wave = (phase_sum[23:0] > {pulse_width, 12'b0}) ? 8'hFF : 8'h00;
      MODE_NOISE: wave = noise_flip ? noise_pick(lfsr_step) : noise_byte;
      MODE_TEST:  wave = freq_word[15:8];
      default:    wave = '0;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    last_noise_bit_next = last_noise_bit;
    noise_byte_next     = noise_byte;
    noise_lfsr_next     = noise_lfsr;
    if (go) begin
      unique case (item.func)
        FUNC_TICK: begin
          if (wave_mode == MODE_TRI || wave_mode == MODE_SAW ||
              wave_mode == MODE_PULSE || wave_mode == MODE_NOISE) begin
            phase_next = phase_sum;
          end
          if (wave_mode == MODE_NOISE && noise_flip) begin
            last_noise_bit_next = phase_sum[21];
            noise_lfsr_next     = lfsr_step;
            noise_byte_next     = noise_pick(lfsr_step);
          end
        end
        FUNC_RESTART: begin
          phase_next          = '0;
          last_noise_bit_next = 1'b0;
          noise_byte_next     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      last_noise_bit <= 1'b0;
      noise_byte     <= '0;
      noise_lfsr     <= LFSR_RESET;
    end else begin
      phase          <= phase_next;
      last_noise_bit <= last_noise_bit_next;
      noise_byte     <= noise_byte_next;
      noise_lfsr     <= noise_lfsr_next;
    end
  end

  // the shift map is invertible, so a non-zero seed never reaches zero
  `VWO_ASSERT_SAME(a_lfsr_nonzero, 1'b1, noise_lfsr != '0, "noise lfsr reached zero")
  `VWO_ASSERT_NEXT(a_restart_clears, go && item.func == FUNC_RESTART,
                   phase == '0 && noise_byte == '0, "restart left phase or noise set")

endmodule
